// ===== hdl/brb_pkg.sv =====
// Shared constants, field widths and operation codes of the byte ring buffer FIFO.
package brb_pkg;

   localparam int DEPTH_DEF    = 1024;
   localparam int MAX_PEEK_DEF = 64;

   localparam int OP_W   = 2;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 10;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_PEEK   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

endpackage

// ===== hdl/brb_if.sv =====
// Request and response channel interfaces of the byte ring buffer FIFO.
interface brb_req_if;
   logic                        valid;
   logic                        ready;
   logic [brb_pkg::OP_W-1:0]    op;
   logic [brb_pkg::BYTE_W-1:0]  in_byte;
   logic [brb_pkg::CNT_W-1:0]   count;

   modport source (output valid, output op, output in_byte, output count, input ready);
   modport sink   (input valid, input op, input in_byte, input count, output ready);
endinterface

interface brb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [brb_pkg::BYTE_W-1:0]  out_byte;
   logic                        byte_valid;
   logic                        last;
   logic                        accepted;
   logic [brb_pkg::CNT_W-1:0]   removed;
   logic [brb_pkg::CNT_W-1:0]   fill_level;
   logic [brb_pkg::CNT_W-1:0]   free_space;

   modport source (output valid, output out_byte, output byte_valid, output last,
                   output accepted, output removed, output fill_level, output free_space,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input last,
                   input accepted, input removed, input fill_level, input free_space,
                   output ready);
endinterface

// ===== hdl/brb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/brb_ring_add.sv =====
// Shared modular adder: advances a ring pointer by a step, wrapping at DEPTH.
module brb_ring_add #(
   parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
   input  logic [$clog2(DEPTH)-1:0] base,
   input  logic [$clog2(DEPTH)-1:0] step,
   output logic [$clog2(DEPTH)-1:0] sum
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [PTR_W:0] raw;

   always_comb begin
      raw = {1'b0, base} + {1'b0, step};
      // step stays below DEPTH, so one conditional subtract wraps
      if (raw >= (PTR_W+1)'(DEPTH)) begin
         sum = PTR_W'(raw - (PTR_W+1)'(DEPTH));
      end else begin
         sum = raw[PTR_W-1:0];
      end
   end

endmodule

// ===== hdl/byte_ring_buffer_fifo_core.sv =====
// Top level of the byte ring buffer FIFO: sequencer, pointers, fill count and response register.
// Push, remove and no-op: one result per request; the next request is taken once it is loaded.
// Peek of n bytes: each byte is read through the registered read port of the storage RAM, then
// emitted as one byte beat; the request side is busy until the last byte beat is loaded.
// Synchronous reset clears head, tail, fill count, response valid and sequencer; not the storage.
// Response stalls hold the sequencer; the single response register decouples the two sides.
module byte_ring_buffer_fifo_core #(
   parameter int DEPTH    = brb_pkg::DEPTH_DEF,
   parameter int MAX_PEEK = brb_pkg::MAX_PEEK_DEF
) (
   input  logic      clock,
   input  logic      reset,
   brb_req_if.sink   req_bus,
   brb_rsp_if.source rsp_bus
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int RUN_W = $clog2(MAX_PEEK + 1);
   // compare width covering the count field, the fill count and the peek cap
   localparam int W     = (PTR_W > brb_pkg::CNT_W) ? PTR_W : brb_pkg::CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PK_RD,
      ST_PK_EMIT
   } state_type;

   // control state
   state_type                   state_ff, state_in;
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [PTR_W-1:0]            tail_ff, tail_in;
   logic [PTR_W-1:0]            fill_ff, fill_in;
   logic [RUN_W-1:0]            remain_ff, remain_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // latched request and peek walk pointer
   brb_pkg::op_type             op_ff, op_in;
   logic [brb_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic [brb_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]            addr_ff, addr_in;

   // response payload registers
   logic [brb_pkg::BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic                        byte_valid_ff, byte_valid_in;
   logic                        last_ff, last_in;
   logic                        accepted_ff, accepted_in;
   logic [brb_pkg::CNT_W-1:0]   removed_ff, removed_in;
   logic [brb_pkg::CNT_W-1:0]   fill_level_ff, fill_level_in;
   logic [brb_pkg::CNT_W-1:0]   free_space_ff, free_space_in;

   // result being loaded this cycle
   logic                        rsp_load;
   logic [brb_pkg::BYTE_W-1:0]  r_byte;
   logic                        r_valid;
   logic                        r_acc;
   logic [brb_pkg::CNT_W-1:0]   r_rem;

   logic [PTR_W-1:0]            ring_base, ring_step, ring_sum;
   logic                        ram_we, ram_re;
   logic [brb_pkg::BYTE_W-1:0]  ram_rdata;

   logic                        out_free;
   logic                        full;
   logic [W-1:0]                fill_ext, cnt_ext, rem_n, pk_cap, pk_n;
   logic [31:0]                 fill32, free32;

   brb_ring_add #(.DEPTH(DEPTH)) u_ring (
      .base (ring_base),
      .step (ring_step),
      .sum  (ring_sum)
   );

   brb_ram #(.WIDTH(brb_pkg::BYTE_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (byte_ff),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_byte   = out_byte_ff;
   assign rsp_bus.byte_valid = byte_valid_ff;
   assign rsp_bus.last       = last_ff;
   assign rsp_bus.accepted   = accepted_ff;
   assign rsp_bus.removed    = removed_ff;
   assign rsp_bus.fill_level = fill_level_ff;
   assign rsp_bus.free_space = free_space_ff;

   // the response slot can take a beat when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign full     = (fill_ff == PTR_W'(DEPTH - 1));

   // clamp counts: remove takes min(count, fill), peek also caps at MAX_PEEK
   assign fill_ext = W'(fill_ff);
   assign cnt_ext  = W'(count_ff);
   assign rem_n    = (cnt_ext < fill_ext) ? cnt_ext : fill_ext;
   assign pk_cap   = (cnt_ext < W'(MAX_PEEK)) ? cnt_ext : W'(MAX_PEEK);
   assign pk_n     = (pk_cap < fill_ext) ? pk_cap : fill_ext;

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      remain_in = remain_ff;
      op_in     = op_ff;
      byte_in   = byte_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;

      ring_base = addr_ff;
      ring_step = PTR_W'(1);
      ram_we    = 1'b0;
      ram_re    = 1'b0;

      rsp_load  = 1'b0;
      r_byte    = '0;
      r_valid   = 1'b0;
      r_acc     = 1'b0;
      r_rem     = '0;
      last_in   = last_ff;

      case (state_ff)
         ST_IDLE: begin
            // capture the request beat
            if (req_bus.valid) begin
               op_in    = brb_pkg::op_type'(req_bus.op);
               byte_in  = req_bus.in_byte;
               count_in = req_bus.count;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               case (op_ff)
                  brb_pkg::OP_PUSH: begin
                     ring_base = tail_ff;
                     ring_step = PTR_W'(1);
                     // drop the byte when full
                     if (!full) begin
                        ram_we  = 1'b1;
                        tail_in = ring_sum;
                        fill_in = fill_ff + PTR_W'(1);
                        r_acc   = 1'b1;
                     end
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                  end
                  brb_pkg::OP_REMOVE: begin
                     ring_base = head_ff;
                     ring_step = PTR_W'(rem_n);
                     head_in   = ring_sum;
                     fill_in   = fill_ff - PTR_W'(rem_n);
                     r_rem     = brb_pkg::CNT_W'(rem_n);
                     rsp_load  = 1'b1;
                     state_in  = ST_IDLE;
                  end
                  brb_pkg::OP_PEEK: begin
                     if (pk_n == '0) begin
                        // nothing to give: a single marker beat
                        rsp_load = 1'b1;
                        state_in = ST_IDLE;
                     end else begin
                        addr_in   = head_ff;
                        remain_in = RUN_W'(pk_n);
                        state_in  = ST_PK_RD;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               endcase
               last_in = 1'b1;
            end
         end
         ST_PK_RD: begin
            ram_re   = 1'b1;
            state_in = ST_PK_EMIT;
         end
         ST_PK_EMIT: begin
            // emit the fetched byte, then advance the walk pointer
            if (out_free) begin
               rsp_load  = 1'b1;
               r_byte    = ram_rdata;
               r_valid   = 1'b1;
               last_in   = (remain_ff == RUN_W'(1));
               ring_base = addr_ff;
               ring_step = PTR_W'(1);
               addr_in   = ring_sum;
               remain_in = remain_ff - RUN_W'(1);
               state_in  = (remain_ff == RUN_W'(1)) ? ST_IDLE : ST_PK_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fill level and free space after this beat's update, reported on 10 bits
   assign fill32 = 32'(fill_in);
   assign free32 = 32'(DEPTH - 1) - fill32;

   always_comb begin
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      accepted_in   = accepted_ff;
      removed_in    = removed_ff;
      fill_level_in = fill_level_ff;
      free_space_in = free_space_ff;
      if (rsp_load) begin
         out_byte_in   = r_byte;
         byte_valid_in = r_valid;
         accepted_in   = r_acc;
         removed_in    = r_rem;
         fill_level_in = fill32[brb_pkg::CNT_W-1:0];
         free_space_in = free32[brb_pkg::CNT_W-1:0];
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      byte_ff       <= byte_in;
      count_ff      <= count_in;
      addr_ff       <= addr_in;
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_ff       <= last_in;
      accepted_ff   <= accepted_in;
      removed_ff    <= removed_in;
      fill_level_ff <= fill_level_in;
      free_space_ff <= free_space_in;
   end

   // one slot always stays empty
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= PTR_W'(DEPTH - 1))
      else $error("fill count exceeds capacity");

   // fill count tracks the distance from head to tail
   a_fill_ptrs: assert property (@(posedge clock) disable iff (reset)
      (tail_ff >= head_ff) ? (fill_ff == tail_ff - head_ff)
                           : (32'(fill_ff) == 32'(tail_ff) + 32'(DEPTH) - 32'(head_ff)))
      else $error("fill count disagrees with head and tail");

   // a peek walk never runs with an empty run counter
   a_peek_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PK_RD || state_ff == ST_PK_EMIT) |-> (remain_ff != '0))
      else $error("peek walk with no bytes left");

   // a stored push grows the fill count by exactly one
   a_push_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && r_acc) |=> (fill_ff == $past(fill_ff) + PTR_W'(1)))
      else $error("accepted push did not advance fill count");

endmodule

// ===== tb/byte_ring_buffer_fifo_core_tb.sv =====
// Self-checking testbench of the byte ring buffer FIFO core: queue-fed driver, monitor, predictor.
module byte_ring_buffer_fifo_core_tb;

   localparam int RING_DEPTH = brb_pkg::DEPTH_DEF;
   localparam int PEEK_CAP   = brb_pkg::MAX_PEEK_DEF;
   localparam int BYTE_W     = brb_pkg::BYTE_W;
   localparam int CNT_W      = brb_pkg::CNT_W;

   // One request beat waiting to be driven; hold makes the driver drain all responses first.
   typedef struct {
      brb_pkg::op_type   op;
      logic [BYTE_W-1:0] data;
      logic [CNT_W-1:0]  cnt;
      bit                hold;
   } feed_item_type;

   // One response beat as the FIFO should present it.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              last;
      logic              accepted;
      logic [CNT_W-1:0]  removed;
      logic [CNT_W-1:0]  fill_level;
      logic [CNT_W-1:0]  free_space;
   } fifo_beat_type;

   typedef enum {RDY_FREE, RDY_RANDOM, RDY_STALL} ready_style_type;

   logic clock;
   logic reset;

   brb_req_if req_bus ();
   brb_rsp_if rsp_bus ();

   byte_ring_buffer_fifo_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow copy of the ring: bytes, head (oldest byte) and tail (next free slot).
   logic [BYTE_W-1:0] ring_copy [RING_DEPTH];
   int ring_head = 0;
   int ring_tail = 0;

   feed_item_type op_feed_q [$];
   fifo_beat_type due_beats [$];

   int total_items = 0;
   int sent_items  = 0;
   int fail_count  = 0;

   // Sender burst/gap state.
   int burst_left = 1;
   int gap_left   = 0;
   feed_item_type next_item;

   // Receiver stall state.
   ready_style_type ready_style = RDY_FREE;
   int style_left = 0;
   int stall_left = 0;

   fifo_beat_type want;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int ring_fill();
      return (ring_tail + RING_DEPTH - ring_head) % RING_DEPTH;
   endfunction

   // Append one expected beat; fill and free space come from the state after the update.
   function automatic void queue_beat(logic [BYTE_W-1:0] data, logic dv, logic lst, logic acc,
                                      int rem);
      fifo_beat_type b;
      int fill;
      fill = ring_fill();
      b.out_byte   = data;
      b.byte_valid = dv;
      b.last       = lst;
      b.accepted   = acc;
      b.removed    = CNT_W'(rem);
      b.fill_level = CNT_W'(fill);
      b.free_space = CNT_W'(RING_DEPTH - 1 - fill);
      due_beats.push_back(b);
   endfunction

   // Update the shadow ring for one accepted request and queue the beats it causes.
   function automatic void apply_fifo_op(brb_pkg::op_type op, logic [BYTE_W-1:0] data,
                                         logic [CNT_W-1:0] cnt);
      int fill;
      int n;
      int h;
      int next_tail;
      fill = ring_fill();
      case (op)
         brb_pkg::OP_PUSH: begin
            next_tail = (ring_tail + 1) % RING_DEPTH;
            if (next_tail != ring_head) begin
               ring_copy[ring_tail] = data;
               ring_tail = next_tail;
               queue_beat(8'h00, 1'b0, 1'b1, 1'b1, 0);
            end else begin
               // full: drop the byte
               queue_beat(8'h00, 1'b0, 1'b1, 1'b0, 0);
            end
         end
         brb_pkg::OP_PEEK: begin
            n = cnt;
            if (n > PEEK_CAP) n = PEEK_CAP;
            if (n > fill) n = fill;
            if (n == 0) begin
               // nothing to give: one invalid beat
               queue_beat(8'h00, 1'b0, 1'b1, 1'b0, 0);
            end else begin
               h = ring_head;
               for (int i = 0; i < n; i++) begin
                  queue_beat(ring_copy[h], 1'b1, (i == n - 1), 1'b0, 0);
                  h = (h + 1) % RING_DEPTH;
               end
            end
         end
         brb_pkg::OP_REMOVE: begin
            n = (cnt < fill) ? cnt : fill;
            ring_head = (ring_head + n) % RING_DEPTH;
            queue_beat(8'h00, 1'b0, 1'b1, 1'b0, n);
         end
         default: begin
            queue_beat(8'h00, 1'b0, 1'b1, 1'b0, 0);
         end
      endcase
   endfunction

   task automatic add_item(input brb_pkg::op_type op, input logic [BYTE_W-1:0] data,
                           input logic [CNT_W-1:0] cnt, input bit hold = 1'b0);
      feed_item_type it;
      it.op   = op;
      it.data = data;
      it.cnt  = cnt;
      it.hold = hold;
      op_feed_q.push_back(it);
      total_items++;
   endtask

   // Mostly small counts near the fill, with zero, the peek cap edges and full 10-bit
   // values mixed in.
   function automatic logic [CNT_W-1:0] pick_count(int span);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CNT_W'(PEEK_CAP - 1 + $urandom_range(0, 2));
         2, 3:    return CNT_W'($urandom());
         default: return CNT_W'($urandom_range(1, span + 3));
      endcase
   endfunction

   task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
                              input logic [CNT_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
         fail_count++;
      end
   endtask

   // Driver: present queued beats in bursts with random gaps; update the predictor on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_fifo_op(brb_pkg::op_type'(req_bus.op), req_bus.in_byte, req_bus.count);
            sent_items <= sent_items + 1;
         end
         // Hold the current beat while it waits for ready; otherwise pick the next one.
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (op_feed_q.size() != 0 &&
                         !(op_feed_q[0].hold && due_beats.size() != 0)) begin
               next_item = op_feed_q.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.op      <= next_item.op;
               req_bus.in_byte <= next_item.data;
               req_bus.count   <= next_item.cnt;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switch between free flow, random ready and long stalls every so often.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            ready_style <= ready_style_type'($urandom_range(0, 2));
            style_left  <= $urandom_range(20, 200);
         end else begin
            style_left <= style_left - 1;
         end
         case (ready_style)
            RDY_FREE: begin
               rsp_bus.ready <= 1'b1;
            end
            RDY_RANDOM: begin
               rsp_bus.ready <= ($urandom_range(0, 9) < 7);
            end
            default: begin
               if (stall_left != 0) begin
                  stall_left <= stall_left - 1;
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
                  if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 16);
               end
            end
         endcase
      end
   end

   // Monitor: compare every accepted response beat with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_beats.size() == 0) begin
            $display("%0t: response beat with none expected, expected nothing, actual byte %0h",
                     $time, rsp_bus.out_byte);
            fail_count++;
         end else begin
            want = due_beats.pop_front();
            check_field("out_byte",   CNT_W'(want.out_byte),   CNT_W'(rsp_bus.out_byte));
            check_field("byte_valid", CNT_W'(want.byte_valid), CNT_W'(rsp_bus.byte_valid));
            check_field("last",       CNT_W'(want.last),       CNT_W'(rsp_bus.last));
            check_field("accepted",   CNT_W'(want.accepted),   CNT_W'(rsp_bus.accepted));
            check_field("removed",    want.removed,            rsp_bus.removed);
            check_field("fill_level", want.fill_level,         rsp_bus.fill_level);
            check_field("free_space", want.free_space,         rsp_bus.free_space);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int r;
      int k;
      bit swept;
      swept = 1'b0;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.op      = brb_pkg::OP_NOP;
      req_bus.in_byte = '0;
      req_bus.count   = '0;
      rsp_bus.ready   = 1'b0;

      // Directed: empty peek and remove, no-op, byte extremes, zero count, cap and overshoot.
      add_item(brb_pkg::OP_PEEK,   8'h00, 10'd5);
      add_item(brb_pkg::OP_REMOVE, 8'h00, 10'd3);
      add_item(brb_pkg::OP_NOP,    8'hFF, 10'h3FF);
      add_item(brb_pkg::OP_PUSH,   8'h00, 10'd0);
      add_item(brb_pkg::OP_PUSH,   8'hFF, 10'h3FF);
      add_item(brb_pkg::OP_PUSH,   8'hA5, 10'd0);
      add_item(brb_pkg::OP_PUSH,   8'h5A, 10'd0);
      add_item(brb_pkg::OP_PEEK,   8'h00, 10'd0);
      add_item(brb_pkg::OP_PEEK,   8'h00, 10'd2);
      add_item(brb_pkg::OP_PEEK,   8'hFF, 10'h3FF);
      add_item(brb_pkg::OP_REMOVE, 8'h00, 10'd0);
      add_item(brb_pkg::OP_REMOVE, 8'h00, 10'd1);
      add_item(brb_pkg::OP_PEEK,   8'h00, 10'd10);
      add_item(brb_pkg::OP_NOP,    8'h00, 10'd0);
      add_item(brb_pkg::OP_REMOVE, 8'h00, 10'h3FF);
      add_item(brb_pkg::OP_PUSH,   8'h3C, 10'd0);
      add_item(brb_pkg::OP_PEEK,   8'h00, 10'd64);

      // Random: mostly push runs followed by a peek and a remove, the rest single noisy beats.
      while (total_items < 430) begin
         if (!swept && total_items >= 200) begin
            // Drain, build a run past the peek cap, then peek around the cap.
            add_item(brb_pkg::OP_REMOVE, 8'h00, 10'h3FF, 1'b1);
            repeat (PEEK_CAP + 6) add_item(brb_pkg::OP_PUSH, 8'($urandom()), CNT_W'($urandom()));
            add_item(brb_pkg::OP_PEEK,   8'h00, 10'h3FF);
            add_item(brb_pkg::OP_PEEK,   8'h00, 10'd65);
            add_item(brb_pkg::OP_PEEK,   8'h00, 10'd63);
            add_item(brb_pkg::OP_NOP,    8'($urandom()), CNT_W'($urandom()));
            add_item(brb_pkg::OP_REMOVE, 8'h00, 10'd1);
            add_item(brb_pkg::OP_PUSH,   8'($urandom()), 10'd0);
            add_item(brb_pkg::OP_PUSH,   8'($urandom()), 10'd0);
            add_item(brb_pkg::OP_REMOVE, 8'h00, 10'd1000);
            add_item(brb_pkg::OP_PEEK,   8'h00, 10'd30);
            add_item(brb_pkg::OP_REMOVE, 8'h00, 10'h3FF);
            swept = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 60) begin
            k = $urandom_range(1, 12);
            repeat (k) add_item(brb_pkg::OP_PUSH, 8'($urandom()), CNT_W'($urandom()),
                                ($urandom_range(0, 49) == 0));
            add_item(brb_pkg::OP_PEEK, 8'($urandom()), pick_count(k));
            add_item(brb_pkg::OP_REMOVE, 8'($urandom()),
                     ($urandom_range(0, 3) == 0) ? pick_count(k) : CNT_W'(k));
         end else begin
            add_item(brb_pkg::op_type'($urandom_range(0, 3)), 8'($urandom()), pick_count(16),
                     ($urandom_range(0, 49) == 0));
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to be taken, every response to arrive, then let the pipe settle.
      while (sent_items != total_items) @(negedge clock);
      while (due_beats.size() != 0) @(negedge clock);
      repeat (24) @(negedge clock);

      if (fail_count == 0) begin
         $display("byte_ring_buffer_fifo_core_tb passed");
      end else begin
         $display("byte_ring_buffer_fifo_core_tb failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #80_000_000;
      $display("byte_ring_buffer_fifo_core_tb failed");
      $finish;
   end

endmodule
